// File: sv/fdf_pkg.sv
`timescale 1ns / 1ps

package fdf_pkg;

   localparam int TAPS       = 52;
   localparam int IDX_W      = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int CSR_W      = 6;
   localparam int COEF_IDX_W = 6;
   localparam int COEF_W     = 16;
   localparam int SAMPLE_W   = 12;
   localparam int OUT_W      = 16;
   localparam int FRAC_W     = 15;
   localparam int PROD_W     = COEF_W + SAMPLE_W + 1;
   localparam int ACC_W      = PROD_W + IDX_W;
   localparam int Q_W        = ACC_W - FRAC_W;
   localparam int OUT_MAX    = 2 ** (OUT_W - 1) - 1;

   localparam logic [CSR_W-1:0] TAPS_RESET = CSR_W'(52);

   localparam logic ACTION_LOAD   = 1'b0;
   localparam logic ACTION_SAMPLE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RUN,
      ST_DRAIN1,
      ST_DRAIN2,
      ST_OUT
   } fdf_state_type;

   typedef struct packed {
      logic             capture;
      logic             coef_write;
      logic             acc_clear;
      logic             issue;
      logic [IDX_W-1:0] issue_idx;
      logic             out_load;
   } fdf_cmd_type;

   typedef struct packed {
      logic out_busy;
   } fdf_status_type;

endpackage

// File: sv/fdf_if.sv
`timescale 1ns / 1ps

interface fdf_req_if;
   import fdf_pkg::*;

   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [COEF_IDX_W-1:0]        coef_index;
   logic signed [COEF_W-1:0]     coef_value;
   logic [SAMPLE_W-1:0]          sample;

   modport source (output valid, action, coef_index, coef_value, sample, input ready);
   modport sink   (input valid, action, coef_index, coef_value, sample, output ready);
endinterface

interface fdf_rsp_if;
   import fdf_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [OUT_W-1:0]  filtered;
   logic                     saturated;

   modport source (output valid, filtered, saturated, input ready);
   modport sink   (input valid, filtered, saturated, output ready);
endinterface

// File: sv/fdf_ram.sv
`timescale 1ns / 1ps

module fdf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 52
) (
   input  logic                                      clock,
   input  logic                                      write_enable,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] write_addr,
   input  logic [WIDTH-1:0]                          write_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] read_addr,
   output logic [WIDTH-1:0]                          read_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
      read_data <= mem[read_addr];
   end

endmodule

// File: sv/fdf_ctrl.sv
`timescale 1ns / 1ps

module fdf_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_action,
   output logic                          req_ready,
   input  logic                          csr_write_enable,
   input  logic [fdf_pkg::CSR_W-1:0]     csr_write_data,
   output fdf_pkg::fdf_cmd_type          cmd,
   input  fdf_pkg::fdf_status_type       status
);
   import fdf_pkg::*;

   fdf_state_type     state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CSR_W-1:0]  taps_ff;
   logic [IDX_W-1:0]  last_idx;

   // zero taps act as one, too many act as TAPS
   always_comb begin
      if (taps_ff == '0) begin
         last_idx = '0;
      end else if (int'(taps_ff) > TAPS) begin
         last_idx = IDX_W'(TAPS - 1);
      end else begin
         last_idx = IDX_W'(taps_ff - CSR_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         taps_ff  <= TAPS_RESET;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (csr_write_enable) begin
            taps_ff <= csr_write_data;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cmd           = '0;
      cmd.issue_idx = idx_ff;
      req_ready     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_action == ACTION_SAMPLE) begin
                  cmd.acc_clear = 1'b1;
                  idx_in        = last_idx;
                  state_in      = ST_RUN;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            cmd.coef_write = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (idx_ff == '0) begin
               state_in = ST_DRAIN1;
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         ST_DRAIN1: state_in = ST_DRAIN2;
         ST_DRAIN2: state_in = ST_OUT;
         ST_OUT: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_sample_starts_run: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == ACTION_SAMPLE |=> state_ff == ST_RUN)
      else $error("sample transaction did not start the tap sweep");

   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN && idx_ff == '0 |=> state_ff == ST_DRAIN1)
      else $error("tap sweep did not end at tap zero");

   a_out_returns: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && !status.out_busy |=> state_ff == ST_IDLE)
      else $error("result not handed over when output was free");
`endif

endmodule

// File: sv/fdf_datapath.sv
`timescale 1ns / 1ps

module fdf_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fdf_pkg::fdf_cmd_type                 cmd,
   output fdf_pkg::fdf_status_type              status,
   input  logic [fdf_pkg::COEF_IDX_W-1:0]       req_coef_index,
   input  logic signed [fdf_pkg::COEF_W-1:0]    req_coef_value,
   input  logic [fdf_pkg::SAMPLE_W-1:0]         req_sample,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic signed [fdf_pkg::OUT_W-1:0]     rsp_filtered,
   output logic                                 rsp_saturated
);
   import fdf_pkg::*;

   logic [COEF_IDX_W-1:0]      coef_idx_ff;
   logic signed [COEF_W-1:0]   coef_val_ff;
   logic [SAMPLE_W-1:0]        sample_ff;

   logic [TAPS-1:0]            dvalid_ff, cvalid_ff;

   logic                       s1_v_ff, s1_first_ff, dv_q_ff, cv_q_ff;
   logic [IDX_W-1:0]           s1_idx_ff;
   logic                       s1_v_in, s1_first_in, dv_q_in, cv_q_in;

   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic                       s2_v_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;

   logic                       rsp_valid_ff;
   logic signed [OUT_W-1:0]    filtered_ff, filtered_in;
   logic                       saturated_ff, saturated_in;

   logic [IDX_W-1:0]           d_raddr;
   logic [SAMPLE_W-1:0]        d_rdata, d_new;
   logic [COEF_W-1:0]          c_rdata;
   logic signed [COEF_W-1:0]   c_cur;
   logic                       coef_we;
   logic [IDX_W-1:0]           coef_waddr;

   logic signed [ACC_W-1:0]    acc_adj;
   logic signed [Q_W-1:0]      q, q_max, q_min;

   assign d_raddr    = cmd.issue_idx - IDX_W'(1);
   assign coef_we    = cmd.coef_write && (int'(coef_idx_ff) < TAPS);
   assign coef_waddr = IDX_W'(coef_idx_ff);

   fdf_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_delay_ram (
      .clock        (clock),
      .write_enable (s1_v_ff),
      .write_addr   (s1_idx_ff),
      .write_data   (d_new),
      .read_addr    (d_raddr),
      .read_data    (d_rdata)
   );

   fdf_ram #(.WIDTH(COEF_W), .DEPTH(TAPS)) u_coef_ram (
      .clock        (clock),
      .write_enable (coef_we),
      .write_addr   (coef_waddr),
      .write_data   (coef_val_ff),
      .read_addr    (cmd.issue_idx),
      .read_data    (c_rdata)
   );

   // tap zero takes the new sample; unwritten entries read as zero
   always_comb begin
      s1_v_in     = cmd.issue;
      s1_first_in = (cmd.issue_idx == '0);
      dv_q_in     = (cmd.issue_idx != '0) && dvalid_ff[d_raddr];
      cv_q_in     = cvalid_ff[cmd.issue_idx];
      d_new       = s1_first_ff ? sample_ff : (dv_q_ff ? d_rdata : '0);
      c_cur       = cv_q_ff ? $signed(c_rdata) : '0;
      prod_in     = c_cur * $signed({1'b0, d_new});
      if (cmd.acc_clear) begin
         acc_in = '0;
      end else if (s2_v_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   // divide by 2^15 truncating toward zero, then clip
   always_comb begin
      acc_adj = acc_ff + (acc_ff[ACC_W-1] ? ACC_W'(2 ** FRAC_W - 1) : '0);
      q       = acc_adj[ACC_W-1:FRAC_W];
      q_max   = Q_W'(OUT_MAX);
      q_min   = ~q_max;
      if (q > q_max) begin
         filtered_in  = OUT_W'(OUT_MAX);
         saturated_in = 1'b1;
      end else if (q < q_min) begin
         filtered_in  = ~OUT_W'(OUT_MAX);
         saturated_in = 1'b1;
      end else begin
         filtered_in  = q[OUT_W-1:0];
         saturated_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         coef_idx_ff <= req_coef_index;
         coef_val_ff <= req_coef_value;
         sample_ff   <= req_sample;
      end
      s1_first_ff <= s1_first_in;
      s1_idx_ff   <= cmd.issue_idx;
      dv_q_ff     <= dv_q_in;
      cv_q_ff     <= cv_q_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      if (cmd.out_load) begin
         filtered_ff  <= filtered_in;
         saturated_ff <= saturated_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvalid_ff    <= '0;
         cvalid_ff    <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s1_v_ff;
         if (s1_v_ff) begin
            dvalid_ff[s1_idx_ff] <= 1'b1;
         end
         if (coef_we) begin
            cvalid_ff[coef_waddr] <= 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_filtered    = filtered_ff;
   assign rsp_saturated   = saturated_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(cmd.out_load && status.out_busy))
      else $error("pending result overwritten");

   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && saturated_ff |->
         filtered_ff == OUT_W'(OUT_MAX) || filtered_ff == ~OUT_W'(OUT_MAX))
      else $error("clip flag without clipped value");
`endif

endmodule

// File: sv/fir_filter_direct_form.sv
`timescale 1ns / 1ps

// Port    | Dir | Transaction
// --------+-----+---------------------------------------------------------
// req_*   | in  | action, coef_index, coef_value, sample (valid/ready)
// rsp_*   | out | filtered, saturated (valid/ready), one per sample
// csr_*   | in  | taps_in_use, written on csr_write_enable
//
// A sample runs one multiply-accumulate per tap, read from the delay and
// coefficient RAMs one port each, shifting the delay line in that sweep;
// no request is taken meanwhile. A coefficient load captures, then writes.
// After reset both tables read as zero through per-entry valid flags.
// A result waits in the output register while a new request is taken;
// the next result holds in the final step until the output is free.

module fir_filter_direct_form (
   input  logic                       clock,
   input  logic                       reset,
   fdf_req_if.sink                    req_chan,
   fdf_rsp_if.source                  rsp_chan,
   input  logic                       csr_write_enable,
   input  logic [fdf_pkg::CSR_W-1:0]  csr_write_data
);
   import fdf_pkg::*;

   fdf_cmd_type    cmd;
   fdf_status_type status;

   fdf_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_action       (req_chan.action),
      .req_ready        (req_chan.ready),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status)
   );

   fdf_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_coef_index (req_chan.coef_index),
      .req_coef_value (req_chan.coef_value),
      .req_sample     (req_chan.sample),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_filtered   (rsp_chan.filtered),
      .rsp_saturated  (rsp_chan.saturated)
   );

endmodule
